>>> src/ctp_pkg.sv
// ----------------------------------------------------------------------------
// Cubic trajectory point package
// Shared constants, configuration register indexes and control types.
// ----------------------------------------------------------------------------
package ctp_pkg;

  localparam int STEP_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF = 8;
  localparam int POS_BITS_DEF  = 13;

  localparam int CFG_IDX_BITS = 2;

  // Reset values of the configuration registers.
  localparam int START_POS_RST  = 90;
  localparam int FINISH_POS_RST = 120;
  localparam int STEP_COUNT_RST = 50;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_POS  = 2'd0,
    CFG_FINISH_POS = 2'd1,
    CFG_STEP_COUNT = 2'd2
  } ctp_cfg_idx_t;

  // Per-beat flags that travel alongside the arithmetic.
  typedef struct packed {
    logic past;   // index beyond the step count
    logic zero;   // index is zero
    logic neg;    // finish lies below start
  } ctp_ctrl_t;

endpackage

>>> src/ctp_in_if.sv
// ----------------------------------------------------------------------------
// Cubic trajectory point input channel
// Valid/ready channel carrying one step index per beat.
// ----------------------------------------------------------------------------
interface ctp_in_if #(
  parameter int STEP_BITS = 10
);
  logic                 valid;
  logic                 ready;
  logic [STEP_BITS-1:0] step_index;

  modport source (output valid, output step_index, input ready);
  modport sink   (input valid, input step_index, output ready);
endinterface

>>> src/ctp_out_if.sv
// ----------------------------------------------------------------------------
// Cubic trajectory point result channel
// Valid/ready channel carrying one setpoint per beat.
// ----------------------------------------------------------------------------
interface ctp_out_if #(
  parameter int OUT_BITS = 21
);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] position;
  logic                       past_end;

  modport source (output valid, output position, output past_end, input ready);
  modport sink   (input valid, input position, input past_end, output ready);
endinterface

>>> src/cubic_trajectory_point.sv
// ----------------------------------------------------------------------------
// Cubic trajectory point
// One setpoint of a cubic, zero-end-velocity motion profile for one axis.
// ----------------------------------------------------------------------------
// For a step index k this block returns start + (finish - start) *
// k^2 * (3N - 2k) / N^3 in signed fixed point with FRAC_BITS fractional bits,
// rounded to nearest with exact halves rounded in the direction of travel.
// An index above N gives the finish position with past_end set. The block is
// fully pipelined and takes one index every clock cycle. Each index passes
// through four stages that form the polynomial and the rounded dividend,
// then one restoring divider stage per quotient bit, then a final register
// that applies the start offset and the saturation. When the result beat
// is stalled the whole pipeline holds, so nothing is lost or repeated.
// Configuration writes are expected only while the pipeline is empty.
module cubic_trajectory_point #(
  parameter int STEP_BITS = ctp_pkg::STEP_BITS_DEF,
  parameter int FRAC_BITS = ctp_pkg::FRAC_BITS_DEF,
  parameter int POS_BITS  = ctp_pkg::POS_BITS_DEF,
  parameter int CFG_BITS  = (POS_BITS > STEP_BITS) ? POS_BITS : STEP_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ctp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]              cfg_wdata,
  ctp_in_if.sink                           in_ch,
  ctp_out_if.source                        out_ch
);
  import ctp_pkg::*;

  localparam int OW = POS_BITS + FRAC_BITS;
  localparam int DB = 3 * STEP_BITS;
  localparam int W  = OW + DB + 1;

  // Configuration registers.
  logic signed [POS_BITS-1:0] start_pos_r;
  logic signed [POS_BITS-1:0] finish_pos_r;
  logic [STEP_BITS-1:0]       step_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pos_r  <= POS_BITS'(START_POS_RST);
      finish_pos_r <= POS_BITS'(FINISH_POS_RST);
      step_count_r <= STEP_BITS'(STEP_COUNT_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_POS:  start_pos_r  <= cfg_wdata[POS_BITS-1:0];
        CFG_FINISH_POS: finish_pos_r <= cfg_wdata[POS_BITS-1:0];
        CFG_STEP_COUNT: step_count_r <= cfg_wdata[STEP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // The pipeline advances whenever the output register is free or drained.
  logic out_valid_r;
  logic en;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  logic          p_valid;
  ctp_ctrl_t     p_ctrl;
  logic [OW-1:0] p_base, p_fin;
  logic [W-1:0]  p_dvd;
  logic [DB-1:0] p_den;

  ctp_poly #(
    .STEP_BITS(STEP_BITS),
    .FRAC_BITS(FRAC_BITS),
    .POS_BITS (POS_BITS),
    .OW       (OW),
    .DB       (DB),
    .W        (W)
  ) u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .k_in      (in_ch.step_index),
    .start_pos (start_pos_r),
    .finish_pos(finish_pos_r),
    .step_count(step_count_r),
    .valid_o   (p_valid),
    .ctrl_o    (p_ctrl),
    .base_o    (p_base),
    .fin_o     (p_fin),
    .dvd_o     (p_dvd),
    .den_o     (p_den)
  );

  logic          d_valid;
  ctp_ctrl_t     d_ctrl;
  logic [OW-1:0] d_base, d_fin, d_quot;

  ctp_div #(
    .OW(OW),
    .DB(DB),
    .W (W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .valid_i(p_valid),
    .ctrl_i (p_ctrl),
    .base_i (p_base),
    .fin_i  (p_fin),
    .dvd_i  (p_dvd),
    .den_i  (p_den),
    .valid_o(d_valid),
    .ctrl_o (d_ctrl),
    .base_o (d_base),
    .fin_o  (d_fin),
    .quot_o (d_quot)
  );

  // Final stage: saturation past the end, exact start at index zero
  // (which also covers a zero step count), else start plus signed offset.
  logic [OW-1:0] pos_nxt;
  logic [OW-1:0] pos_r;
  logic          past_r;

  always_comb begin
    if (d_ctrl.past) begin
      pos_nxt = d_fin;
    end else if (d_ctrl.zero) begin
      pos_nxt = d_base;
    end else if (d_ctrl.neg) begin
      pos_nxt = d_base - d_quot;
    end else begin
      pos_nxt = d_base + d_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r  <= pos_nxt;
      past_r <= d_ctrl.past;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.position = pos_r;
  assign out_ch.past_end = past_r;

endmodule

>>> src/ctp_poly.sv
// ----------------------------------------------------------------------------
// Cubic trajectory point polynomial front end
// Four stages that form the rounded dividend and the divisor N^3.
// ----------------------------------------------------------------------------
module ctp_poly #(
  parameter int STEP_BITS = 10,
  parameter int FRAC_BITS = 8,
  parameter int POS_BITS  = 13,
  parameter int OW        = POS_BITS + FRAC_BITS,
  parameter int DB        = 3 * STEP_BITS,
  parameter int W         = OW + DB + 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [STEP_BITS-1:0]       k_in,
  input  logic signed [POS_BITS-1:0] start_pos,
  input  logic signed [POS_BITS-1:0] finish_pos,
  input  logic [STEP_BITS-1:0]       step_count,
  output logic                       valid_o,
  output ctp_pkg::ctp_ctrl_t         ctrl_o,
  output logic [OW-1:0]              base_o,
  output logic [OW-1:0]              fin_o,
  output logic [W-1:0]               dvd_o,
  output logic [DB-1:0]              den_o
);
  import ctp_pkg::*;

  localparam int S  = STEP_BITS;
  localparam int H  = (DB + 1) / 2;

  // Stage 1
  logic                v1_r;
  ctp_ctrl_t           c1_r, c1_nxt;
  logic [OW-1:0]       base1_r, fin1_r, magf1_r, magf1_nxt;
  logic [2*S-1:0]      k2_r, n2_r;
  logic [S+1:0]        t1_r, t1_nxt;
  logic [S-1:0]        n1_r;
  logic signed [POS_BITS:0] diff;
  logic [POS_BITS:0]   mag_w;

  always_comb begin
    diff = (POS_BITS+1)'(finish_pos) - (POS_BITS+1)'(start_pos);
    c1_nxt.past = k_in > step_count;
    c1_nxt.zero = k_in == '0;
    c1_nxt.neg  = diff[POS_BITS];
    mag_w       = diff[POS_BITS] ? (POS_BITS+1)'(-diff) : diff;
    magf1_nxt   = OW'(mag_w[POS_BITS-1:0]) << FRAC_BITS;
    // 3N - 2k; only meaningful when k <= N, which keeps it non-negative.
    t1_nxt      = (S+2)'(step_count) * (S+2)'(3) - ((S+2)'(k_in) << 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r    <= c1_nxt;
      base1_r <= OW'(start_pos) << FRAC_BITS;
      fin1_r  <= OW'(finish_pos) << FRAC_BITS;
      magf1_r <= magf1_nxt;
      k2_r    <= (2*S)'(k_in) * (2*S)'(k_in);
      n2_r    <= (2*S)'(step_count) * (2*S)'(step_count);
      t1_r    <= t1_nxt;
      n1_r    <= step_count;
    end
  end

  // Stage 2: numerator k^2(3N-2k) and divisor N^3, both below 2^(3S).
  logic                v2_r;
  ctp_ctrl_t           c2_r;
  logic [OW-1:0]       base2_r, fin2_r, magf2_r;
  logic [DB-1:0]       num2_r, den2_r;
  logic [DB+1:0]       num_full;

  assign num_full = (DB+2)'(k2_r) * (DB+2)'(t1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r    <= c1_r;
      base2_r <= base1_r;
      fin2_r  <= fin1_r;
      magf2_r <= magf1_r;
      num2_r  <= num_full[DB-1:0];
      den2_r  <= DB'((DB)'(n2_r) * (DB)'(n1_r));
    end
  end

  // Stage 3: the wide product is split into two partial products.
  logic                v3_r;
  ctp_ctrl_t           c3_r;
  logic [OW-1:0]       base3_r, fin3_r;
  logic [DB-1:0]       den3_r;
  logic [OW+H-1:0]     pl3_r;
  logic [OW+DB-H-1:0]  ph3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_r    <= c2_r;
      base3_r <= base2_r;
      fin3_r  <= fin2_r;
      den3_r  <= den2_r;
      pl3_r   <= (OW+H)'(magf2_r) * (OW+H)'(num2_r[H-1:0]);
      ph3_r   <= (OW+DB-H)'(magf2_r) * (OW+DB-H)'(num2_r[DB-1:H]);
    end
  end

  // Stage 4: recombine and add half the divisor for round to nearest.
  logic                v4_r;
  ctp_ctrl_t           c4_r;
  logic [OW-1:0]       base4_r, fin4_r;
  logic [DB-1:0]       den4_r;
  logic [W-1:0]        dvd4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4_r    <= c3_r;
      base4_r <= base3_r;
      fin4_r  <= fin3_r;
      den4_r  <= den3_r;
      dvd4_r  <= W'(pl3_r) + (W'(ph3_r) << H) + W'(den3_r >> 1);
    end
  end

  assign valid_o = v4_r;
  assign ctrl_o  = c4_r;
  assign base_o  = base4_r;
  assign fin_o   = fin4_r;
  assign dvd_o   = dvd4_r;
  assign den_o   = den4_r;

endmodule

>>> src/ctp_div.sv
// ----------------------------------------------------------------------------
// Cubic trajectory point divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ctp_div #(
  parameter int OW = 21,
  parameter int DB = 30,
  parameter int W  = OW + DB + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  ctp_pkg::ctp_ctrl_t ctrl_i,
  input  logic [OW-1:0]      base_i,
  input  logic [OW-1:0]      fin_i,
  input  logic [W-1:0]       dvd_i,
  input  logic [DB-1:0]      den_i,
  output logic               valid_o,
  output ctp_pkg::ctp_ctrl_t ctrl_o,
  output logic [OW-1:0]      base_o,
  output logic [OW-1:0]      fin_o,
  output logic [OW-1:0]      quot_o
);
  import ctp_pkg::*;

  logic          v_a    [OW+1];
  ctp_ctrl_t     c_a    [OW+1];
  logic [OW-1:0] base_a [OW+1];
  logic [OW-1:0] fin_a  [OW+1];
  logic [W-1:0]  rem_a  [OW+1];
  logic [DB-1:0] den_a  [OW+1];
  logic [OW-1:0] q_a    [OW+1];

  assign v_a[0]    = valid_i;
  assign c_a[0]    = ctrl_i;
  assign base_a[0] = base_i;
  assign fin_a[0]  = fin_i;
  assign rem_a[0]  = dvd_i;
  assign den_a[0]  = den_i;
  assign q_a[0]    = '0;

  // The quotient is known to fit in OW bits, so each stage tests the
  // divisor shifted to one quotient bit position, from the top down.
  for (genvar j = 1; j <= OW; j++) begin : g_stage
    localparam int B = OW - j;
    logic [W:0]    trial;
    logic [OW-1:0] q_nxt;

    always_comb begin
      trial    = {1'b0, rem_a[j-1]} - ((W+1)'(den_a[j-1]) << B);
      q_nxt    = q_a[j-1];
      q_nxt[B] = ~trial[W];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_a[j] <= 1'b0;
      end else if (en) begin
        v_a[j] <= v_a[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_a[j]    <= c_a[j-1];
        base_a[j] <= base_a[j-1];
        fin_a[j]  <= fin_a[j-1];
        den_a[j]  <= den_a[j-1];
        q_a[j]    <= q_nxt;
        rem_a[j]  <= trial[W] ? rem_a[j-1] : trial[W-1:0];
      end
    end
  end

  assign valid_o = v_a[OW];
  assign ctrl_o  = c_a[OW];
  assign base_o  = base_a[OW];
  assign fin_o   = fin_a[OW];
  assign quot_o  = q_a[OW];

endmodule

>>> bench/cubic_trajectory_point_test.sv
// ----------------------------------------------------------------------------
// Cubic trajectory point testbench
// Drives step indexes through several register settings and checks every
// setpoint against an in-bench model of the cubic profile.
// ----------------------------------------------------------------------------
module cubic_trajectory_point_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ctp_pkg::*;

  localparam int STEP_W = STEP_BITS_DEF;
  localparam int FRAC_W = FRAC_BITS_DEF;
  localparam int POS_W  = POS_BITS_DEF;
  localparam int OUT_W  = POS_W + FRAC_W;
  localparam int CFG_W  = (POS_W > STEP_W) ? POS_W : STEP_W;
  localparam int LATENCY = 5 + POS_W + FRAC_W;
  // Index one past the register list; a write there must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic signed [OUT_W-1:0] position;
    logic                    past_end;
  } setpoint_t;

  // Holds the register copy, predicts setpoints for accepted indexes and
  // matches them in order against the result beats.
  class setpoint_book;
    logic signed [POS_W-1:0] start_pos;
    logic signed [POS_W-1:0] finish_pos;
    logic [STEP_W-1:0]       step_count;
    setpoint_t               due[$];
    int                      errors;

    function new();
      start_pos  = POS_W'(START_POS_RST);
      finish_pos = POS_W'(FINISH_POS_RST);
      step_count = STEP_W'(STEP_COUNT_RST);
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_START_POS:  start_pos  = value[POS_W-1:0];
        CFG_FINISH_POS: finish_pos = value[POS_W-1:0];
        CFG_STEP_COUNT: step_count = value[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_index(logic [STEP_W-1:0] k);
      setpoint_t          sp;
      longint             s, f, d;
      longint unsigned    mag, n, kk, num, den, quot;
      logic [OUT_W-1:0]   base;
      s = start_pos;
      f = finish_pos;
      n = step_count;
      kk = k;
      base = OUT_W'(s <<< FRAC_W);
      sp.past_end = 1'b0;
      if (kk > n) begin
        sp.position = OUT_W'(f <<< FRAC_W);
        sp.past_end = 1'b1;
      end else if (kk == 0) begin
        sp.position = base;
      end else begin
        d    = f - s;
        mag  = (d < 0) ? longint'(-d) : d;
        num  = kk * kk * (3 * n - 2 * kk);
        den  = n * n * n;
        quot = ((mag << FRAC_W) * num + den / 2) / den;
        sp.position = (d < 0) ? base - OUT_W'(quot) : base + OUT_W'(quot);
      end
      due.push_back(sp);
    endfunction

    task report(string what);
      errors++;
      $display("%0t MISMATCH: %s", $realtime, what);
    endtask

    task check_setpoint(logic signed [OUT_W-1:0] pos, logic past);
      setpoint_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected beat position=%0d past_end=%0b", pos, past));
      end else begin
        want = due.pop_front();
        if (pos !== want.position)
          report($sformatf("position %0d, expected %0d", pos, want.position));
        if (past !== want.past_end)
          report($sformatf("past_end %0b, expected %0b", past, want.past_end));
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_START_POS;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  ctp_in_if  #(.STEP_BITS(STEP_W)) in_ch ();
  ctp_out_if #(.OUT_BITS(OUT_W))   out_ch ();

  cubic_trajectory_point dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  setpoint_book book = new();

  // Idling controls shared by the sender and the receiver. quiet turns off
  // all random idling for the closing part of the run; hold_request asks the
  // receiver for one long stall so the pipeline backs up into the input.
  bit quiet = 1'b0;
  int hold_request = 0;
  int hold_left = 0;
  int ready_idle = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Every accepted index is predicted at the edge where it is taken, and
  // every accepted result beat is checked at its own edge.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      book.note_index(in_ch.step_index);
    if (rst_n && out_ch.valid && out_ch.ready)
      book.check_setpoint(out_ch.position, out_ch.past_end);
  end

  // Receiver side: random stall bursts, plus the long stall when one is
  // requested. The long stall is counted here in cycles.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready = 1'b0;
    end else if (ready_idle > 0) begin
      ready_idle--;
      out_ch.ready = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      ready_idle = $urandom_range(1, 6) - 1;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    book.write_reg(idx, value);
  endtask

  task automatic setup(int start, int finish, int count);
    write_reg(CFG_START_POS, CFG_W'(start));
    write_reg(CFG_FINISH_POS, CFG_W'(finish));
    write_reg(CFG_STEP_COUNT, CFG_W'(count));
  endtask

  // Offers one index, sometimes after a short gap, and returns once the
  // beat has been taken. Valid stays high straight into the next beat when
  // no gap follows.
  task automatic send_index(logic [STEP_W-1:0] k);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.step_index = k;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Lowers valid and waits until every predicted setpoint has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (book.due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_directed();
    int n;
    n = book.step_count;
    send_index(STEP_W'(0));
    send_index(STEP_W'(1));
    if (n > 1) send_index(STEP_W'(n - 1));
    send_index(STEP_W'(n));
    send_index(STEP_W'(n + 1));
    send_index('1);
  endtask

  // Mostly indexes inside the profile, with a share past its end.
  task automatic send_random(int count);
    int n;
    n = book.step_count;
    repeat (count) begin
      if ($urandom_range(0, 4) == 0)
        send_index(STEP_W'($urandom_range(0, (1 << STEP_W) - 1)));
      else
        send_index(STEP_W'($urandom_range(0, n)));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.step_index = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The reset settings first, then the same with a few bit patterns.
    send_directed();
    send_index(10'h155);
    send_index(10'h2AA);
    drain();

    // Full-scale travel upward and downward at the largest step count.
    setup(-4096, 4095, 1023);
    send_directed();
    send_index(10'h200);
    drain();
    setup(4095, -4096, 1023);
    send_directed();
    send_index(10'h155);
    send_index(10'h2AA);
    drain();

    // A one-step profile, then a zero step count written with upper data
    // bits set that the count register must drop, then a write past the
    // register list that must change nothing.
    setup(-7, 3, 1);
    send_directed();
    drain();
    setup(0, 0, 13'h1C00);
    send_directed();
    drain();
    write_reg(CFG_UNUSED, 13'h1FFF);
    send_index(STEP_W'(0));
    send_index(STEP_W'(5));
    drain();

    // Random phases. In the first the receiver stalls for a long stretch
    // while indexes keep coming; in the second the sender pauses midway
    // until every setpoint is back.
    setup(-1234, 2345, 200);
    send_directed();
    hold_request = 3 * LATENCY;
    send_random(80);
    drain();

    setup(1500, -900, 1023);
    send_random(40);
    drain();
    send_random(40);
    drain();

    setup($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
          $urandom_range(1, 1023));
    send_random(80);
    drain();

    setup($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
          $urandom_range(1, 40));
    send_random(80);
    drain();

    // Closing phase runs back to back on both sides.
    quiet = 1'b1;
    setup(-4096, -4096 + $urandom_range(0, 8191), $urandom_range(1, 1023));
    send_random(80);
    drain();

    book.errors += book.due.size();
    if (book.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
src/ctp_pkg.sv
src/ctp_in_if.sv
src/ctp_out_if.sv
src/ctp_poly.sv
src/ctp_div.sv
src/cubic_trajectory_point.sv
bench/cubic_trajectory_point_test.sv
